// ----- design/affinv_pkg.sv -----
`timescale 1ns / 1ps

package affinv_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int SQ_W        = 2 * DATA_W;
    // quotient is bounded by 2^(2F), so 2F+1 bits hold it
    localparam int QUO_W       = 2 * FRAC_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t WORD_MAX = word_t'({1'b0, {(DATA_W-1){1'b1}}});
    localparam word_t WORD_MIN = word_t'({1'b1, {(DATA_W-1){1'b0}}});

    // classified matrix, front to back
    typedef struct packed {
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic [DATA_W-1:0] mag_c;
        logic [DATA_W-1:0] mag_d;
        logic              neg_a;
        logic              neg_b;
        logic              neg_c;
        logic              neg_d;
        word_t             shift_x;
        word_t             shift_y;
        logic [SQ_W-1:0]   len0;
        logic [SQ_W-1:0]   len1;
        logic              zero0;
        logic              zero1;
    } queue_t;

    typedef struct packed {
        word_t inv_col0_row0;
        word_t inv_col0_row1;
        word_t inv_col1_row0;
        word_t inv_col1_row1;
        word_t inv_shift_x;
        word_t inv_shift_y;
        logic  zero_column;
        logic  saturated;
    } res_t;

endpackage

// ----- design/affinv_in_if.sv -----
`timescale 1ns / 1ps

interface affinv_in_if;
    import affinv_pkg::*;

    logic  valid;
    logic  ready;
    word_t col0_row0;
    word_t col0_row1;
    word_t col1_row0;
    word_t col1_row1;
    word_t shift_x;
    word_t shift_y;

    modport source (
        output valid, col0_row0, col0_row1, col1_row0, col1_row1, shift_x, shift_y,
        input  ready
    );
    modport sink (
        input  valid, col0_row0, col0_row1, col1_row0, col1_row1, shift_x, shift_y,
        output ready
    );
endinterface

// ----- design/affinv_out_if.sv -----
`timescale 1ns / 1ps

interface affinv_out_if;
    import affinv_pkg::*;

    logic  valid;
    logic  ready;
    word_t inv_col0_row0;
    word_t inv_col0_row1;
    word_t inv_col1_row0;
    word_t inv_col1_row1;
    word_t inv_shift_x;
    word_t inv_shift_y;
    logic  zero_column;
    logic  saturated;

    modport source (
        output valid, inv_col0_row0, inv_col0_row1, inv_col1_row0, inv_col1_row1,
               inv_shift_x, inv_shift_y, zero_column, saturated,
        input  ready
    );
    modport sink (
        input  valid, inv_col0_row0, inv_col0_row1, inv_col1_row0, inv_col1_row1,
               inv_shift_x, inv_shift_y, zero_column, saturated,
        output ready
    );
endinterface

// ----- design/affinv_front.sv -----
`timescale 1ns / 1ps

module affinv_front (
    input  logic                clk,
    input  logic                rst_n,
    affinv_in_if.sink           matrix,
    output logic                push_valid,
    input  logic                push_ready,
    output affinv_pkg::queue_t  push_data
);
    import affinv_pkg::*;

    logic                    ce;
    logic                    v_reg;
    logic signed [SQ_W-1:0]  sq_a_next, sq_b_next, sq_c_next, sq_d_next;
    logic [SQ_W-1:0]         sq_a_reg, sq_b_reg, sq_c_reg, sq_d_reg;
    logic [DATA_W-1:0]       mag_a_next, mag_b_next, mag_c_next, mag_d_next;
    logic [DATA_W-1:0]       mag_a_reg, mag_b_reg, mag_c_reg, mag_d_reg;
    logic                    neg_a_reg, neg_b_reg, neg_c_reg, neg_d_reg;
    word_t                   shift_x_reg, shift_y_reg;

    assign ce           = !v_reg || push_ready;
    assign matrix.ready = ce;

    assign sq_a_next = matrix.col0_row0 * matrix.col0_row0;
    assign sq_b_next = matrix.col0_row1 * matrix.col0_row1;
    assign sq_c_next = matrix.col1_row0 * matrix.col1_row0;
    assign sq_d_next = matrix.col1_row1 * matrix.col1_row1;

    // magnitude; the most negative word maps to 2^31 unsigned
    assign mag_a_next = matrix.col0_row0[DATA_W-1] ? $unsigned(-matrix.col0_row0)
                                                   : $unsigned(matrix.col0_row0);
    assign mag_b_next = matrix.col0_row1[DATA_W-1] ? $unsigned(-matrix.col0_row1)
                                                   : $unsigned(matrix.col0_row1);
    assign mag_c_next = matrix.col1_row0[DATA_W-1] ? $unsigned(-matrix.col1_row0)
                                                   : $unsigned(matrix.col1_row0);
    assign mag_d_next = matrix.col1_row1[DATA_W-1] ? $unsigned(-matrix.col1_row1)
                                                   : $unsigned(matrix.col1_row1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (ce)
        begin
            v_reg <= matrix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce && matrix.valid)
        begin
            sq_a_reg    <= $unsigned(sq_a_next);
            sq_b_reg    <= $unsigned(sq_b_next);
            sq_c_reg    <= $unsigned(sq_c_next);
            sq_d_reg    <= $unsigned(sq_d_next);
            mag_a_reg   <= mag_a_next;
            mag_b_reg   <= mag_b_next;
            mag_c_reg   <= mag_c_next;
            mag_d_reg   <= mag_d_next;
            neg_a_reg   <= matrix.col0_row0[DATA_W-1];
            neg_b_reg   <= matrix.col0_row1[DATA_W-1];
            neg_c_reg   <= matrix.col1_row0[DATA_W-1];
            neg_d_reg   <= matrix.col1_row1[DATA_W-1];
            shift_x_reg <= matrix.shift_x;
            shift_y_reg <= matrix.shift_y;
        end
    end

    // squared column lengths; sum of two squares stays below 2^64
    always_comb
    begin
        push_data.mag_a   = mag_a_reg;
        push_data.mag_b   = mag_b_reg;
        push_data.mag_c   = mag_c_reg;
        push_data.mag_d   = mag_d_reg;
        push_data.neg_a   = neg_a_reg;
        push_data.neg_b   = neg_b_reg;
        push_data.neg_c   = neg_c_reg;
        push_data.neg_d   = neg_d_reg;
        push_data.shift_x = shift_x_reg;
        push_data.shift_y = shift_y_reg;
        push_data.len0    = sq_a_reg + sq_b_reg;
        push_data.len1    = sq_c_reg + sq_d_reg;
        push_data.zero0   = (push_data.len0 == '0);
        push_data.zero1   = (push_data.len1 == '0);
    end

    assign push_valid = v_reg;

endmodule

// ----- design/affinv_fifo.sv -----
`timescale 1ns / 1ps

module affinv_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  affinv_pkg::queue_t  wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output affinv_pkg::queue_t  rd_data
);
    import affinv_pkg::*;

    queue_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ----- design/affinv_div.sv -----
`timescale 1ns / 1ps

module affinv_div (
    input  logic                          clk,
    input  logic                          ce,
    input  logic [affinv_pkg::DATA_W-1:0] mag0,
    input  logic [affinv_pkg::DATA_W-1:0] mag1,
    input  logic [affinv_pkg::SQ_W-1:0]   len,
    output logic [affinv_pkg::QUO_W-1:0]  quo0,
    output logic [affinv_pkg::QUO_W-1:0]  quo1
);
    import affinv_pkg::*;

    // floor(mag * 2^(2F) / len), one quotient bit per stage, two lanes share the divisor
    logic [SQ_W-1:0]  rem0_reg [QUO_W];
    logic [SQ_W-1:0]  rem1_reg [QUO_W];
    logic [SQ_W-1:0]  len_reg  [QUO_W];
    logic [QUO_W-1:0] quo0_reg [QUO_W];
    logic [QUO_W-1:0] quo1_reg [QUO_W];
    logic [SQ_W-1:0]  rem0_next [QUO_W];
    logic [SQ_W-1:0]  rem1_next [QUO_W];
    logic [SQ_W-1:0]  len_next  [QUO_W];
    logic [QUO_W-1:0] quo0_next [QUO_W];
    logic [QUO_W-1:0] quo1_next [QUO_W];

    // {quotient bit, new remainder}
    function automatic logic [SQ_W:0] div_step(logic [SQ_W-1:0] rem, logic din,
                                               logic [SQ_W-1:0] dv);
        logic [SQ_W+1:0] trial;
        trial = {1'b0, rem, din} - {2'b00, dv};
        if (trial[SQ_W+1])
        begin
            div_step = {1'b0, rem[SQ_W-2:0], din};
        end
        else
        begin
            div_step = {1'b1, trial[SQ_W-1:0]};
        end
    endfunction

    always_comb
    begin
        logic [SQ_W-1:0]  r0, r1, dv;
        logic             b0, b1;
        logic [QUO_W-1:0] q0, q1;
        logic [SQ_W:0]    s0, s1;
        for (int k = 0; k < QUO_W; k++)
        begin
            if (k == 0)
            begin
                // top part of the dividend is mag >> 1; then mag[0], then zeros
                r0 = SQ_W'(mag0[DATA_W-1:1]);
                r1 = SQ_W'(mag1[DATA_W-1:1]);
                b0 = mag0[0];
                b1 = mag1[0];
                dv = len;
                q0 = '0;
                q1 = '0;
            end
            else
            begin
                r0 = rem0_reg[k-1];
                r1 = rem1_reg[k-1];
                b0 = 1'b0;
                b1 = 1'b0;
                dv = len_reg[k-1];
                q0 = quo0_reg[k-1];
                q1 = quo1_reg[k-1];
            end
            s0 = div_step(r0, b0, dv);
            s1 = div_step(r1, b1, dv);
            rem0_next[k] = s0[SQ_W-1:0];
            rem1_next[k] = s1[SQ_W-1:0];
            len_next[k]  = dv;
            quo0_next[k] = {q0[QUO_W-2:0], s0[SQ_W]};
            quo1_next[k] = {q1[QUO_W-2:0], s1[SQ_W]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                rem0_reg[k] <= rem0_next[k];
                rem1_reg[k] <= rem1_next[k];
                len_reg[k]  <= len_next[k];
                quo0_reg[k] <= quo0_next[k];
                quo1_reg[k] <= quo1_next[k];
            end
        end
    end

    assign quo0 = quo0_reg[QUO_W-1];
    assign quo1 = quo1_reg[QUO_W-1];

endmodule

// ----- design/affinv_back.sv -----
`timescale 1ns / 1ps

module affinv_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  affinv_pkg::queue_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output affinv_pkg::res_t    out_data
);
    import affinv_pkg::*;

    typedef struct packed {
        logic  neg_a;
        logic  neg_b;
        logic  neg_c;
        logic  neg_d;
        word_t shift_x;
        word_t shift_y;
        logic  zero0;
        logic  zero1;
    } side_t;

    typedef struct packed {
        word_t val;
        logic  sat;
    } entry_t;

    logic                    ce;
    logic                    v_reg    [QUO_W];
    side_t                   side_reg [QUO_W];
    logic [QUO_W-1:0]        q_a, q_b, q_c, q_d;
    entry_t                  en_a, en_b, en_c, en_d;
    entry_t                  sh_x, sh_y;

    logic                    e_v_reg, m_v_reg, o_v_reg;
    word_t                   e_a_reg, e_b_reg, e_c_reg, e_d_reg, e_tx_reg, e_ty_reg;
    logic                    e_sat_reg, e_zero_reg;
    word_t                   m_a_reg, m_b_reg, m_c_reg, m_d_reg;
    logic signed [SQ_W-1:0]  m_px0_reg, m_px1_reg, m_py0_reg, m_py1_reg;
    logic                    m_sat_reg, m_zero_reg;
    res_t                    o_data_reg;

    assign ce       = !o_v_reg || out_ready;
    assign in_ready = ce;

    affinv_div u_div0 (
        .clk  (clk),
        .ce   (ce),
        .mag0 (in_data.mag_a),
        .mag1 (in_data.mag_b),
        .len  (in_data.len0),
        .quo0 (q_a),
        .quo1 (q_b)
    );

    affinv_div u_div1 (
        .clk  (clk),
        .ce   (ce),
        .mag0 (in_data.mag_c),
        .mag1 (in_data.mag_d),
        .len  (in_data.len1),
        .quo0 (q_c),
        .quo1 (q_d)
    );

    // signed entry, clamped; zero column forces zero
    function automatic entry_t make_entry(logic [QUO_W-1:0] q, logic neg, logic zero);
        logic [SQ_W-1:0] qx;
        entry_t          e;
        qx    = SQ_W'(q);
        e.sat = 1'b0;
        if (zero)
        begin
            e.val = '0;
        end
        else if (!neg)
        begin
            if (qx > SQ_W'($unsigned(WORD_MAX)))
            begin
                e.val = WORD_MAX;
                e.sat = 1'b1;
            end
            else
            begin
                e.val = word_t'(qx[DATA_W-1:0]);
            end
        end
        else
        begin
            if (qx > SQ_W'($unsigned(WORD_MIN)))
            begin
                e.val = WORD_MIN;
                e.sat = 1'b1;
            end
            else
            begin
                e.val = word_t'(qx[DATA_W-1:0]);
                e.val = -e.val;
            end
        end
        return e;
    endfunction

    // -floor((p0 + p1) / 2^F), clamped
    function automatic entry_t make_shift(logic signed [SQ_W-1:0] p0,
                                          logic signed [SQ_W-1:0] p1);
        logic signed [SQ_W+1:0] sum, hi, ng;
        entry_t                 e;
        sum   = (SQ_W+2)'(p0) + (SQ_W+2)'(p1);
        hi    = sum >>> FRAC_BITS;
        ng    = -hi;
        e.sat = 1'b0;
        if (ng > (SQ_W+2)'(WORD_MAX))
        begin
            e.val = WORD_MAX;
            e.sat = 1'b1;
        end
        else if (ng < (SQ_W+2)'(WORD_MIN))
        begin
            e.val = WORD_MIN;
            e.sat = 1'b1;
        end
        else
        begin
            e.val = word_t'(ng[DATA_W-1:0]);
        end
        return e;
    endfunction

    assign en_a = make_entry(q_a, side_reg[QUO_W-1].neg_a, side_reg[QUO_W-1].zero0);
    assign en_b = make_entry(q_b, side_reg[QUO_W-1].neg_b, side_reg[QUO_W-1].zero0);
    assign en_c = make_entry(q_c, side_reg[QUO_W-1].neg_c, side_reg[QUO_W-1].zero1);
    assign en_d = make_entry(q_d, side_reg[QUO_W-1].neg_d, side_reg[QUO_W-1].zero1);

    assign sh_x = make_shift(m_px0_reg, m_px1_reg);
    assign sh_y = make_shift(m_py0_reg, m_py1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            e_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < QUO_W; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            e_v_reg <= v_reg[QUO_W-1];
            m_v_reg <= e_v_reg;
            o_v_reg <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side_reg[0].neg_a   <= in_data.neg_a;
            side_reg[0].neg_b   <= in_data.neg_b;
            side_reg[0].neg_c   <= in_data.neg_c;
            side_reg[0].neg_d   <= in_data.neg_d;
            side_reg[0].shift_x <= in_data.shift_x;
            side_reg[0].shift_y <= in_data.shift_y;
            side_reg[0].zero0   <= in_data.zero0;
            side_reg[0].zero1   <= in_data.zero1;
            for (int k = 1; k < QUO_W; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end

            // entry stage
            e_a_reg    <= en_a.val;
            e_b_reg    <= en_b.val;
            e_c_reg    <= en_c.val;
            e_d_reg    <= en_d.val;
            e_sat_reg  <= en_a.sat | en_b.sat | en_c.sat | en_d.sat;
            e_zero_reg <= side_reg[QUO_W-1].zero0 | side_reg[QUO_W-1].zero1;
            e_tx_reg   <= side_reg[QUO_W-1].shift_x;
            e_ty_reg   <= side_reg[QUO_W-1].shift_y;

            // product stage
            m_a_reg    <= e_a_reg;
            m_b_reg    <= e_b_reg;
            m_c_reg    <= e_c_reg;
            m_d_reg    <= e_d_reg;
            m_px0_reg  <= e_a_reg * e_tx_reg;
            m_px1_reg  <= e_b_reg * e_ty_reg;
            m_py0_reg  <= e_c_reg * e_tx_reg;
            m_py1_reg  <= e_d_reg * e_ty_reg;
            m_sat_reg  <= e_sat_reg;
            m_zero_reg <= e_zero_reg;

            // output register
            o_data_reg.inv_col0_row0 <= m_a_reg;
            o_data_reg.inv_col0_row1 <= m_c_reg;
            o_data_reg.inv_col1_row0 <= m_b_reg;
            o_data_reg.inv_col1_row1 <= m_d_reg;
            o_data_reg.inv_shift_x   <= sh_x.val;
            o_data_reg.inv_shift_y   <= sh_y.val;
            o_data_reg.zero_column   <= m_zero_reg;
            o_data_reg.saturated     <= m_sat_reg | sh_x.sat | sh_y.sat;
        end
    end

    assign out_valid = o_v_reg;
    assign out_data  = o_data_reg;

endmodule

// ----- design/affine_inverse_2d_core.sv -----
`timescale 1ns / 1ps

// Inverse of a 2D rotation-scale-translation matrix in signed Q16.16. One matrix beat is
// taken per cycle and one result beat leaves per cycle while the output is not stalled; a
// stall holds the back end, then fills the queue and holds the input. The restoring
// dividers retire one quotient bit per pipeline stage, each quotient a Q16.16 magnitude.
// Columns are assumed orthogonal; each inverse entry is the column entry over the
// column's squared length, truncated toward zero, then transposed. A zero-length column
// gives zero entries and raises zero_column; any clamp to the 32-bit range raises
// saturated. No state is held between matrices.

module affine_inverse_2d_core (
    input  logic          clk,
    input  logic          rst_n,
    affinv_in_if.sink     matrix,
    affinv_out_if.source  inverse
);
    import affinv_pkg::*;

    // front to queue
    logic   push_valid, push_ready;
    queue_t push_data;
    // queue to back
    logic   pop_valid, pop_ready;
    queue_t pop_data;
    res_t   res;

    // front: squares the columns, forms the squared lengths and the entry magnitudes, flags zero columns
    affinv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .matrix     (matrix),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // short queue so a stalled output does not stop the front at once
    affinv_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    // back: divider pipelines, clamp, translation products, output register
    affinv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pop_valid),
        .in_ready  (pop_ready),
        .in_data   (pop_data),
        .out_valid (inverse.valid),
        .out_ready (inverse.ready),
        .out_data  (res)
    );

    assign inverse.inv_col0_row0 = res.inv_col0_row0;
    assign inverse.inv_col0_row1 = res.inv_col0_row1;
    assign inverse.inv_col1_row0 = res.inv_col1_row0;
    assign inverse.inv_col1_row1 = res.inv_col1_row1;
    assign inverse.inv_shift_x   = res.inv_shift_x;
    assign inverse.inv_shift_y   = res.inv_shift_y;
    assign inverse.zero_column   = res.zero_column;
    assign inverse.saturated     = res.saturated;

endmodule

// ----- bench/affine_inverse_2d_core_tb.sv -----
`timescale 1ns / 1ps

// Bench for affine_inverse_2d_core: matrices in, inverse matrices out.
// The driver sends beats in bursts with random gaps. The receiver stalls in bursts
// of its own. A predictor works out each inverse and queues it, and every output
// beat is checked against the oldest prediction.

module affine_inverse_2d_core_tb;
    import affinv_pkg::*;

    typedef struct packed {
        word_t col0_row0;
        word_t col0_row1;
        word_t col1_row0;
        word_t col1_row1;
        word_t shift_x;
        word_t shift_y;
    } matrix_t;

    localparam int N_RANDOM = 1130;

    logic clk;
    logic rst_n;

    affinv_in_if  matrix_bus ();
    affinv_out_if inverse_bus ();

    affine_inverse_2d_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .matrix  (matrix_bus.sink),
        .inverse (inverse_bus.source)
    );

    matrix_t pending_matrices[$];   // waiting to be driven
    res_t    predicted_inverses[$]; // accepted, result not yet seen
    int      errors;
    int      beats_sent;
    int      beats_total;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp to the signed 32-bit range; flags any clamp.
    function automatic longint clamp_word(input longint v, inout bit sat);
        if (v > longint'(32'sh7FFF_FFFF))
        begin
            sat = 1'b1;
            return longint'(32'sh7FFF_FFFF);
        end
        if (v < -longint'(64'h8000_0000))
        begin
            sat = 1'b1;
            return -longint'(64'h8000_0000);
        end
        return v;
    endfunction

    // One inverse entry: entry * 2^(2F) / len, truncated toward zero, clamped.
    function automatic longint inv_entry(input longint a, input bit [63:0] len, inout bit sat);
        bit [63:0] mag;
        bit [63:0] quo;
        bit [63:0] rem;
        bit        capped;
        mag    = (a < 0) ? 64'(-a) : 64'(a);
        capped = 1'b0;
        if (len == 64'd0)
            return 0;
        quo = mag / len;
        rem = mag % len;
        for (int i = 0; i < 2 * FRAC_BITS; i++)
        begin
            if (!capped)
            begin
                if (quo >= (64'd1 << 33))
                begin
                    quo    = 64'd1 << 33;
                    capped = 1'b1;
                end
                else
                begin
                    rem = rem << 1;
                    quo = quo << 1;
                    if (rem >= len)
                    begin
                        rem    = rem - len;
                        quo[0] = 1'b1;
                    end
                end
            end
        end
        if (quo > (64'd1 << 32))
            quo = 64'd1 << 32;
        return clamp_word((a < 0) ? -longint'(quo) : longint'(quo), sat);
    endfunction

    // Negated dot product, floor shift by F on the exact sum.
    function automatic longint neg_dot(input longint r0, input longint t0,
                                       input longint r1, input longint t1, inout bit sat);
        logic signed [64:0] sum;
        sum = 65'(r0 * t0) + 65'(r1 * t1);
        sum = sum >>> FRAC_BITS;
        return clamp_word(-longint'(sum), sat);
    endfunction

    function automatic res_t predict_inverse(input matrix_t m);
        longint    a, b, c, d, tx, ty;
        longint    r00, r01, r10, r11;
        bit [63:0] len0, len1;
        bit        sat;
        res_t      r;
        a    = m.col0_row0;
        b    = m.col0_row1;
        c    = m.col1_row0;
        d    = m.col1_row1;
        tx   = m.shift_x;
        ty   = m.shift_y;
        len0 = 64'(a * a) + 64'(b * b);
        len1 = 64'(c * c) + 64'(d * d);
        sat  = 1'b0;
        r00  = inv_entry(a, len0, sat);
        r10  = inv_entry(b, len0, sat);
        r01  = inv_entry(c, len1, sat);
        r11  = inv_entry(d, len1, sat);
        r.inv_col0_row0 = word_t'(r00);
        r.inv_col0_row1 = word_t'(r01);
        r.inv_col1_row0 = word_t'(r10);
        r.inv_col1_row1 = word_t'(r11);
        r.inv_shift_x   = word_t'(neg_dot(r00, tx, r10, ty, sat));
        r.inv_shift_y   = word_t'(neg_dot(r01, tx, r11, ty, sat));
        r.zero_column   = (len0 == 64'd0) || (len1 == 64'd0);
        r.saturated     = sat;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic matrix_t make_matrix(input word_t a, input word_t b, input word_t c,
                                            input word_t d, input word_t tx, input word_t ty);
        matrix_t m;
        m.col0_row0 = a;
        m.col0_row1 = b;
        m.col1_row0 = c;
        m.col1_row1 = d;
        m.shift_x   = tx;
        m.shift_y   = ty;
        return m;
    endfunction

    // random word, scaled down by a random shift so every magnitude gets a look-in
    function automatic word_t rand_scaled();
        word_t w;
        w = word_t'($urandom);
        return w >>> $urandom_range(31, 0);
    endfunction

    // orthogonal columns: col1 is col0 turned a quarter, scaled by a power of two
    function automatic matrix_t rand_rotation();
        word_t a, b;
        int    k;
        a = rand_scaled();
        b = rand_scaled();
        k = $urandom_range(4, 0);
        if ($urandom_range(1, 0))
            return make_matrix(a, b, -(b >>> k), a >>> k, rand_scaled(), rand_scaled());
        return make_matrix(a, b, b <<< k, -(a <<< k), rand_scaled(), rand_scaled());
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of beats with random gaps between them
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        matrix_t m;
        logic    next_valid;
        if (!rst_n)
        begin
            matrix_bus.valid     <= 1'b0;
            matrix_bus.col0_row0 <= '0;
            matrix_bus.col0_row1 <= '0;
            matrix_bus.col1_row0 <= '0;
            matrix_bus.col1_row1 <= '0;
            matrix_bus.shift_x   <= '0;
            matrix_bus.shift_y   <= '0;
            burst_left           <= 0;
            gap_left             <= 0;
        end
        else if (!matrix_bus.valid || matrix_bus.ready)
        begin
            next_valid = 1'b0;
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_matrices.size() > 0)
            begin
                m          = pending_matrices.pop_front();
                next_valid = 1'b1;
                matrix_bus.col0_row0 <= m.col0_row0;
                matrix_bus.col0_row1 <= m.col0_row1;
                matrix_bus.col1_row0 <= m.col1_row0;
                matrix_bus.col1_row1 <= m.col1_row1;
                matrix_bus.shift_x   <= m.shift_x;
                matrix_bus.shift_y   <= m.shift_y;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    // end of burst: usually a random gap, sometimes none
                    burst_left <= $urandom_range(40, 0);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
                end
            end
            matrix_bus.valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stalls and result checking
    // ------------------------------------------------------------------
    int stall_phase;

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            inverse_bus.ready <= 1'b0;
            stall_phase       <= 0;
        end
        else
        begin
            // output beat first: it cannot be for a matrix taken on this edge
            if (inverse_bus.valid && inverse_bus.ready)
            begin
                if (predicted_inverses.size() == 0)
                begin
                    $error("result beat with no matrix outstanding");
                    errors++;
                end
                else
                begin
                    want = predicted_inverses.pop_front();
                    if (inverse_bus.inv_col0_row0 !== want.inv_col0_row0)
                    begin
                        $error("inv_col0_row0: expected %0d got %0d",
                               want.inv_col0_row0, inverse_bus.inv_col0_row0);
                        errors++;
                    end
                    if (inverse_bus.inv_col0_row1 !== want.inv_col0_row1)
                    begin
                        $error("inv_col0_row1: expected %0d got %0d",
                               want.inv_col0_row1, inverse_bus.inv_col0_row1);
                        errors++;
                    end
                    if (inverse_bus.inv_col1_row0 !== want.inv_col1_row0)
                    begin
                        $error("inv_col1_row0: expected %0d got %0d",
                               want.inv_col1_row0, inverse_bus.inv_col1_row0);
                        errors++;
                    end
                    if (inverse_bus.inv_col1_row1 !== want.inv_col1_row1)
                    begin
                        $error("inv_col1_row1: expected %0d got %0d",
                               want.inv_col1_row1, inverse_bus.inv_col1_row1);
                        errors++;
                    end
                    if (inverse_bus.inv_shift_x !== want.inv_shift_x)
                    begin
                        $error("inv_shift_x: expected %0d got %0d",
                               want.inv_shift_x, inverse_bus.inv_shift_x);
                        errors++;
                    end
                    if (inverse_bus.inv_shift_y !== want.inv_shift_y)
                    begin
                        $error("inv_shift_y: expected %0d got %0d",
                               want.inv_shift_y, inverse_bus.inv_shift_y);
                        errors++;
                    end
                    if (inverse_bus.zero_column !== want.zero_column)
                    begin
                        $error("zero_column: expected %0b got %0b",
                               want.zero_column, inverse_bus.zero_column);
                        errors++;
                    end
                    if (inverse_bus.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0b got %0b",
                               want.saturated, inverse_bus.saturated);
                        errors++;
                    end
                end
            end

            // matrix beat taken: predict its inverse
            if (matrix_bus.valid && matrix_bus.ready)
            begin
                predicted_inverses.push_back(predict_inverse(make_matrix(
                    matrix_bus.col0_row0, matrix_bus.col0_row1, matrix_bus.col1_row0,
                    matrix_bus.col1_row1, matrix_bus.shift_x, matrix_bus.shift_y)));
                beats_sent++;
            end

            // stall pattern: long open windows, then choppy stretches with light and then heavy stalls
            stall_phase <= (stall_phase + 1) % 200;
            if (stall_phase < 80)
                inverse_bus.ready <= 1'b1;
            else if (stall_phase < 140)
                inverse_bus.ready <= ($urandom_range(2, 0) != 0);
            else
                inverse_bus.ready <= ($urandom_range(3, 0) == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        word_t one;
        word_t big;
        word_t low;
        one           = word_t'(1 << FRAC_BITS);
        big           = WORD_MAX;
        low           = WORD_MIN;
        errors        = 0;
        beats_sent    = 0;
        rst_n         = 1'b0;

        // directed: identity, scales, zero columns, extremes, tiny columns that saturate
        pending_matrices.push_back(make_matrix(one, 0, 0, one, 0, 0));
        pending_matrices.push_back(make_matrix(one, 0, 0, one, one * 3, -one * 5));
        pending_matrices.push_back(make_matrix(one * 2, 0, 0, one * 4, one, one));
        pending_matrices.push_back(make_matrix(0, one, -one, 0, one * 7, one * 2));
        pending_matrices.push_back(make_matrix(-one, 0, 0, -one, big, low));
        pending_matrices.push_back(make_matrix(0, 0, 0, 0, one, one));
        pending_matrices.push_back(make_matrix(0, 0, one, 0, one, -one));
        pending_matrices.push_back(make_matrix(one, 0, 0, 0, one, one));
        pending_matrices.push_back(make_matrix(big, big, big, -big, big, big));
        pending_matrices.push_back(make_matrix(low, low, low, low, low, low));
        pending_matrices.push_back(make_matrix(low, 0, 0, low, big, big));
        pending_matrices.push_back(make_matrix(1, 0, 0, 1, 0, 0));
        pending_matrices.push_back(make_matrix(-1, 0, 0, 1, one, one));
        pending_matrices.push_back(make_matrix(1, 1, -1, 1, big, low));
        pending_matrices.push_back(make_matrix(256, 0, 0, -256, one, one));
        pending_matrices.push_back(make_matrix(one >> 8, 0, 0, one >> 8, big, big));
        pending_matrices.push_back(make_matrix(one << 8, 0, 0, one << 8, big, low));
        pending_matrices.push_back(make_matrix(big, 0, 0, 1, -1, -1));
        pending_matrices.push_back(make_matrix(one, one, -one, one, one, one));
        pending_matrices.push_back(make_matrix(3, 4, -4, 3, -one, one));

        // random: mostly orthogonal columns, some raw bit noise, some scaled noise and tiny diagonals
        for (int i = 0; i < N_RANDOM; i++)
        begin
            case ($urandom_range(9, 0))
                0, 1:    pending_matrices.push_back(make_matrix(word_t'($urandom),
                             word_t'($urandom), word_t'($urandom), word_t'($urandom),
                             word_t'($urandom), word_t'($urandom)));
                2:       pending_matrices.push_back(make_matrix(rand_scaled(), rand_scaled(),
                             rand_scaled(), rand_scaled(), word_t'($urandom),
                             word_t'($urandom)));
                3:       pending_matrices.push_back(make_matrix(
                             word_t'($urandom_range(2, 0)) - 1, 0, 0,
                             word_t'($urandom_range(2, 0)) - 1, rand_scaled(), rand_scaled()));
                default: pending_matrices.push_back(rand_rotation());
            endcase
        end
        beats_total = pending_matrices.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (beats_sent == beats_total && predicted_inverses.size() == 0);
        // nothing left in flight; allow for the pipeline depth before closing
        repeat (2 * FRAC_BITS + 20) @(posedge clk);
        if (errors == 0 && predicted_inverses.size() == 0)
            $display("affine_inverse_2d_core_tb OK");
        else
            $display("affine_inverse_2d_core_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("affine_inverse_2d_core_tb NOT OK");
        $finish;
    end

endmodule
